[sv/mip_chain_size_calc_defines.svh]
// Assertion macros for the mip chain size calculator checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MIP_CHAIN_SIZE_CALC_DEFINES_SVH
`define MIP_CHAIN_SIZE_CALC_DEFINES_SVH

// same-cycle implication
`define MCSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcsc check failed");

// next-cycle implication
`define MCSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcsc check failed");

`endif

[sv/mcsc_pkg.sv]
// Shared types, constants and helper functions of the mip chain size calculator.
// No dependencies.
package mcsc_pkg;

  localparam int unsigned DIM_W   = 15;
  localparam int unsigned DEPTH_W = 12;
  localparam int unsigned BPU_W   = 5;
  localparam int unsigned MIP_W   = 5;
  localparam int unsigned FIRST_W = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned SIZE_W  = 48;
  localparam int unsigned PITCH_W = 19;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 112;

  localparam logic [DEPTH_W-1:0] CUBE_FACES = DEPTH_W'(6);

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_WIDTH  = 3'd0,
    REG_BASE_HEIGHT = 3'd1,
    REG_BASE_DEPTH  = 3'd2,
    REG_COMPRESSED  = 3'd3,
    REG_CUBE        = 3'd4,
    REG_BPU         = 3'd5,
    REG_MIP_COUNT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DEPTH_W-1:0] d;
  } dims_t;

  // 4x4 block count along one axis when compressed
  function automatic logic [DIM_W-1:0] blocks(input logic [DIM_W-1:0] n, input logic comp);
    logic [DIM_W:0] t;
    t = {1'b0, n} + (DIM_W+1)'(3);
    return comp ? {1'b0, t[DIM_W:2]} : n;
  endfunction

endpackage

[sv/mcsc_mul_unit.sv]
// Shared registered multiplier of the mip chain size calculator.
// Depends on mcsc_pkg.
module mcsc_mul_unit
  import mcsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [PROD_W-1:0]  prod_o
);

  logic [PROD_W-1:0] prod_q, prod_d;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[sv/mcsc_dims.sv]
// Level dimension tracker: loads the first level's size and halves per level.
// Depends on mcsc_pkg.
module mcsc_dims
  import mcsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               step_i,
  input  logic [FIRST_W-1:0] first_level_i,
  input  dims_t              base_i,
  input  logic               is_cube_i,
  output dims_t              first_o,
  output dims_t              cur_o,
  output logic               all_one_o
);

  dims_t first_q, first_d, cur_q, cur_d;
  logic [DIM_W-1:0]   sh_w, sh_h;
  logic [DEPTH_W-1:0] sh_d;

  always_comb begin
    sh_w = base_i.w >> first_level_i;
    sh_h = base_i.h >> first_level_i;
    sh_d = base_i.d >> first_level_i;
    first_d.w = (sh_w == '0) ? DIM_W'(1) : sh_w;
    first_d.h = (sh_h == '0) ? DIM_W'(1) : sh_h;
    first_d.d = (is_cube_i || sh_d == '0) ? DEPTH_W'(1) : sh_d;
  end

  always_comb begin
    cur_d = cur_q;
    if (load_i) begin
      cur_d = first_d;
    end else if (step_i) begin
      if (cur_q.w > DIM_W'(1))   cur_d.w = cur_q.w >> 1;
      if (cur_q.h > DIM_W'(1))   cur_d.h = cur_q.h >> 1;
      if (cur_q.d > DEPTH_W'(1)) cur_d.d = cur_q.d >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load_i) begin
      first_q <= first_d;
    end
  end

  assign all_one_o = (cur_q.w == DIM_W'(1)) && (cur_q.h == DIM_W'(1)) &&
                     (cur_q.d == DEPTH_W'(1));
  assign first_o   = first_q;
  assign cur_o     = cur_q;

endmodule

[sv/mip_chain_size_calc.sv]
// Top level of the mip chain size calculator: registers, sequencer, output register.
// Depends on mcsc_pkg, mcsc_mul_unit and mcsc_dims.
//
// A request is taken only while the sequencer is idle. Its result appears on the
// output once L levels have been summed (at most LEVEL_LIMIT, fewer when a 1x1x1
// level is reached), and the next request can be accepted from the cycle in which
// that result appears.
// Every product goes through one shared 32x18 multiplier
// with a registered result: one pass for the pitch, then three passes per level
// (width times height, depth or face count times element bytes, then the two
// products together). A finished result waits in the output register and the next
// request is taken meanwhile; that request's result leaves the final state only
// once the waiting one has been taken.
module mip_chain_size_calc
  import mcsc_pkg::*;
#(
  parameter int unsigned LEVEL_LIMIT = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  // first_level[3:0], level_count[8:4], zero fill
  input  logic [IN_W-1:0]  s_tdata_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  // size_bytes[47:0], pitch_bytes[66:48], level_width[81:67],
  // level_height[96:82], level_depth[108:97], level_in_range[109], zero fill
  output logic [OUT_W-1:0] m_tdata_o
);

  localparam int unsigned CNT_W = $clog2(LEVEL_LIMIT + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PITCH = 7'b0000010,
    ST_LVL_A = 7'b0000100,
    ST_LVL_B = 7'b0001000,
    ST_LVL_C = 7'b0010000,
    ST_LVL_D = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  dims_t             base_q, base_d;
  logic              comp_q, comp_d, cube_q, cube_d;
  logic [BPU_W-1:0]  bpu_q, bpu_d;
  logic [MIP_W-1:0]  mip_q, mip_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              last_q, last_d;
  logic              range_q, range_d;
  logic [29:0]       tmp_q, tmp_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PITCH_W-1:0] pitch_q, pitch_d;
  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_q, out_d;

  logic [FIRST_W-1:0] in_first;
  logic [COUNT_W-1:0] in_count;
  logic               in_acc, out_load;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  dims_t              first_dims, cur_dims;
  logic               all_one;
  logic [DEPTH_W-1:0] dfac;
  logic [SIZE_W-1:0]  size_sat;

  assign in_first = s_tdata_i[FIRST_W-1:0];
  assign in_count = s_tdata_i[FIRST_W+COUNT_W-1:FIRST_W];
  assign in_acc   = s_tvalid_i && s_tready_o;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = (state_q == ST_IDLE);

  always_comb begin
    base_d = base_q;
    comp_d = comp_q;
    cube_d = cube_q;
    bpu_d  = bpu_q;
    mip_d  = mip_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_BASE_WIDTH:  base_d.w = cfg_data_i[DIM_W-1:0];
        REG_BASE_HEIGHT: base_d.h = cfg_data_i[DIM_W-1:0];
        REG_BASE_DEPTH:  base_d.d = cfg_data_i[DEPTH_W-1:0];
        REG_COMPRESSED:  comp_d   = cfg_data_i[0];
        REG_CUBE:        cube_d   = cfg_data_i[0];
        REG_BPU:         bpu_d    = cfg_data_i[BPU_W-1:0];
        REG_MIP_COUNT:   mip_d    = cfg_data_i[MIP_W-1:0];
        default: ;
      endcase
    end
  end

  mcsc_dims u_dims (
    .clk_i         (clk_i),
    .load_i        (in_acc),
    .step_i        (state_q == ST_LVL_C),
    .first_level_i (in_first),
    .base_i        (base_q),
    .is_cube_i     (cube_q),
    .first_o       (first_dims),
    .cur_o         (cur_dims),
    .all_one_o     (all_one)
  );

  assign dfac = cube_q ? CUBE_FACES : cur_dims.d;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_PITCH: begin
        mul_a = MUL_A_W'(blocks(first_dims.w, comp_q));
        mul_b = MUL_B_W'(bpu_q);
      end
      ST_LVL_A, ST_LVL_D: begin
        mul_a = MUL_A_W'(blocks(cur_dims.w, comp_q));
        mul_b = MUL_B_W'(blocks(cur_dims.h, comp_q));
      end
      ST_LVL_B: begin
        mul_a = MUL_A_W'(dfac);
        mul_b = MUL_B_W'(bpu_q);
      end
      ST_LVL_C: begin
        mul_a = MUL_A_W'(tmp_q);
        mul_b = prod[MUL_B_W-1:0];
      end
      default: mul_en = 1'b0;
    endcase
  end

  mcsc_mul_unit u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign size_sat = (acc_q[PROD_W-1:SIZE_W] != '0) ? '1 : acc_q[SIZE_W-1:0];
  assign out_load = (state_q == ST_FIN) && (!out_vld_q || m_tready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    range_d   = range_q;
    tmp_d     = tmp_q;
    acc_d     = acc_q;
    pitch_d   = pitch_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (32'(in_count) > LEVEL_LIMIT) begin
            cnt_d = CNT_W'(LEVEL_LIMIT);
          end else begin
            cnt_d = CNT_W'(in_count);
          end
          range_d = ({1'b0, in_first} < mip_q);
          acc_d   = '0;
          state_d = ST_PITCH;
        end
      end
      ST_PITCH: state_d = ST_LVL_A;
      ST_LVL_A: begin
        pitch_d = (prod[PROD_W-1:PITCH_W] != '0) ? '1 : prod[PITCH_W-1:0];
        state_d = (cnt_q == '0) ? ST_FIN : ST_LVL_B;
      end
      ST_LVL_B: begin
        tmp_d   = prod[29:0];
        state_d = ST_LVL_C;
      end
      ST_LVL_C: begin
        last_d  = all_one || (cnt_q == CNT_W'(1));
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = ST_LVL_D;
      end
      ST_LVL_D: begin
        acc_d   = acc_q + prod;
        state_d = last_q ? ST_FIN : ST_LVL_B;
      end
      ST_FIN: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          out_d     = {2'b00, range_q, first_dims.d, first_dims.h, first_dims.w,
                       pitch_q, size_sat};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      base_q    <= '{w: DIM_W'(1), h: DIM_W'(1), d: DEPTH_W'(1)};
      comp_q    <= 1'b0;
      cube_q    <= 1'b0;
      bpu_q     <= BPU_W'(4);
      mip_q     <= MIP_W'(1);
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      base_q    <= base_d;
      comp_q    <= comp_d;
      cube_q    <= cube_d;
      bpu_q     <= bpu_d;
      mip_q     <= mip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    last_q  <= last_d;
    range_q <= range_d;
    tmp_q   <= tmp_d;
    acc_q   <= acc_d;
    pitch_q <= pitch_d;
    out_q   <= out_d;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_q;

endmodule

[sv/mcsc_checker.sv]
// Port-level checker of the mip chain size calculator, bound to the top level.
// Depends on mcsc_pkg and mip_chain_size_calc_defines.svh.
`include "mip_chain_size_calc_defines.svh"

module mcsc_checker
  import mcsc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_tvalid_i,
  input logic             s_tready_o,
  input logic             m_tvalid_o,
  input logic             m_tready_i,
  input logic [OUT_W-1:0] m_tdata_o
);

  `MCSC_ASSERT_NXT(a_busy_after_in, s_tvalid_i && s_tready_o, !s_tready_o)
  `MCSC_ASSERT_IMP(a_result_ends_run, $rose(m_tvalid_o), $rose(s_tready_o))
  `MCSC_ASSERT_NXT(a_out_valid_hold, m_tvalid_o && !m_tready_i, m_tvalid_o)
  `MCSC_ASSERT_NXT(a_out_data_hold, m_tvalid_o && !m_tready_i, $stable(m_tdata_o))

endmodule

bind mip_chain_size_calc mcsc_checker u_mcsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
